// ----- hw/rtl/mhpq_pkg.sv -----
package mhpq_pkg;

  localparam int unsigned CapacityDefault = 64;

  localparam int unsigned PrioW  = 16;
  localparam int unsigned TagW   = 16;
  localparam int unsigned CountW = 7;
  localparam int unsigned StatW  = 2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [StatW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatW-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic             kind;
    logic [PrioW-1:0] new_priority;
    logic [TagW-1:0]  new_tag;
  } in_t;

  typedef struct packed {
    logic [PrioW-1:0]  min_priority;
    logic [TagW-1:0]   min_tag;
    logic [CountW-1:0] entry_count;
    logic [StatW-1:0]  status;
  } out_t;

  // One heap slot: priority in the upper half, tag in the lower half.
  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [TagW-1:0]  tag;
  } entry_t;

endpackage

// ----- hw/rtl/min_heap_priority_queue.sv -----
// Binary min-heap priority queue. Each input transaction is an insert
// (priority, tag) or a remove of the minimum; each gives exactly one result
// with the root after the operation (zero when empty), the entry count and a
// status (ok, insert dropped when full, remove on empty). Entries live in one
// memory of CAPACITY slots with a registered read. Sifting moves a hole one
// heap level per cycle, reading the parent (insert) or both children (remove)
// while writing the entry that moves into the hole, so the time an item takes
// depends on how many heap levels the hole walks through. Equal priorities
// never swap upwards; on removal the right child wins ties between children.
// A result may wait under stall while the next transaction is accepted.
module min_heap_priority_queue #(
  parameter int unsigned CAPACITY = mhpq_pkg::CapacityDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mhpq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mhpq_pkg::out_t out_data_o
);
  import mhpq_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CW   = CntW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DN_LOAD,
    S_DN,
    S_WR,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   size_q, size_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CW-1:0]     nidx_q, nidx_d;
  entry_t            ent_q, ent_d;
  entry_t            root_q, root_d;
  logic [StatW-1:0]  status_q, status_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  entry_t            heap_mem [CAPACITY];
  entry_t            rd_a_q, rd_b_q;
  logic [IdxW-1:0]   rd_addr_a, rd_addr_b;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  entry_t            mem_wdata;

  logic              in_fire;
  logic              out_free;
  logic [CW-1:0]     size_ext;
  logic [CW-1:0]     child_c;
  logic [CW-1:0]     child_r;
  logic [CW-1:0]     right_c;
  logic              pick_right;
  entry_t            pick_e;
  logic [CW-1:0]     pick_idx;
  logic [IdxW-1:0]   parent_c;
  logic [IdxW-1:0]   pidx;
  logic [CntW+CountW-1:0] count_ext;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign size_ext = CW'(size_q);
  assign pidx     = nidx_q[IdxW-1:0];
  assign right_c  = nidx_q + CW'(1);

  // Right child only competes when it exists; it wins ties.
  assign pick_right = (right_c < size_ext) && !(rd_a_q.prio < rd_b_q.prio);
  assign pick_e     = pick_right ? rd_b_q : rd_a_q;
  assign pick_idx   = pick_right ? right_c : nidx_q;

  // Second read port follows the first; clamp past the end of the store.
  assign child_r   = child_c + CW'(1);
  assign rd_addr_b = (child_r < CW'(CAPACITY)) ? child_r[IdxW-1:0] : '0;

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    idx_d       = idx_q;
    nidx_d      = nidx_q;
    ent_d       = ent_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = ent_q;
    child_c     = nidx_q;
    parent_c    = '0;
    count_ext   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          status_d = STATUS_OK;
          if (in_data_i.kind == KIND_INSERT) begin
            if (size_q >= CntW'(CAPACITY)) begin
              status_d = STATUS_FULL;
              state_d  = S_DONE;
            end else begin
              ent_d  = '{prio: in_data_i.new_priority, tag: in_data_i.new_tag};
              idx_d  = size_q[IdxW-1:0];
              size_d = size_q + CntW'(1);
              if (size_q == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = '{prio: in_data_i.new_priority, tag: in_data_i.new_tag};
                state_d   = S_DONE;
              end else begin
                parent_c = IdxW'((size_q - CntW'(1)) >> 1);
                child_c  = CW'(parent_c);
                nidx_d   = CW'(parent_c);
                state_d  = S_UP;
              end
            end
          end else begin
            if (size_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = S_DONE;
            end else begin
              child_c = CW'(size_q - CntW'(1));
              size_d  = size_q - CntW'(1);
              state_d = S_DN_LOAD;
            end
          end
        end
      end

      S_UP: begin
        mem_we = 1'b1;
        if (rd_a_q.prio > ent_q.prio) begin
          // Parent drops into the hole, hole moves up a level.
          mem_wdata = rd_a_q;
          idx_d     = pidx;
          if (pidx == '0) begin
            state_d = S_WR;
          end else begin
            parent_c = (pidx - IdxW'(1)) >> 1;
            child_c  = CW'(parent_c);
            nidx_d   = CW'(parent_c);
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_DN_LOAD: begin
        ent_d   = rd_a_q;
        idx_d   = '0;
        child_c = CW'(1);
        nidx_d  = CW'(1);
        if (CW'(1) >= size_ext) begin
          state_d = S_WR;
        end else begin
          state_d = S_DN;
        end
      end

      S_DN: begin
        mem_we = 1'b1;
        if (pick_e.prio < ent_q.prio) begin
          mem_wdata = pick_e;
          idx_d     = pick_idx[IdxW-1:0];
          child_c   = CW'({pick_idx[IdxW-1:0], 1'b1});
          nidx_d    = child_c;
          if (child_c >= size_ext) begin
            state_d = S_WR;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_WR: begin
        mem_we  = 1'b1;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          count_ext   = (CntW + CountW)'(size_q);
          out_valid_d = 1'b1;
          out_d.min_priority = (size_q == '0) ? '0 : root_q.prio;
          out_d.min_tag      = (size_q == '0) ? '0 : root_q.tag;
          out_d.entry_count  = count_ext[CountW-1:0];
          out_d.status       = status_q;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rd_addr_a = child_c[IdxW-1:0];

  // Shadow of slot zero so the result needs no extra read.
  always_comb begin
    root_d = root_q;
    if (mem_we && (mem_waddr == '0)) begin
      root_d = mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    nidx_q   <= nidx_d;
    ent_q    <= ent_d;
    root_q   <= root_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= heap_mem[rd_addr_a];
    rd_b_q <= heap_mem[rd_addr_b];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((CntW'(mem_waddr) < size_q) || (mem_waddr == '0)))
    else $error("store written beyond the live entries");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.kind == KIND_INSERT) && (size_q < CntW'(CAPACITY)))
    |=> (size_q == CntW'($past(size_q) + CntW'(1))))
    else $error("accepted insert did not add an entry");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside completion");
`endif

endmodule
